[rtl/fbrf_pkg.sv]
// Shared types, codes and helpers of the framebuffer fill and copy unit.
package fbrf_pkg;

  // Build-time defaults of the top-level parameters
  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 128;

  // Number of framebuffers, one byte memory each
  localparam int BUFFER_COUNT = 2;

  // Width of a byte count along one row (255 pixels times 4 bytes)
  localparam int LEN_W    = 10;
  // Width of a row stride in bytes
  localparam int STRIDE_W = 10;
  // Width of a row offset: 8-bit row times 10-bit stride
  localparam int OFF_W    = 18;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;

  // Configuration register indexes
  localparam logic [1:0] CFG_DISP_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_DISP_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_PIXEL_BYTES = 2'd2;

  typedef enum logic [1:0] {
    CMD_SET_PIXEL = 2'd0,
    CMD_GET_PIXEL = 2'd1,
    CMD_FILL_RECT = 2'd2,
    CMD_COPY_RECT = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // One command request
  typedef struct packed {
    cmd_e        command;
    logic        target_buffer;
    logic        source_buffer;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  rect_width;
    logic [7:0]  rect_height;
    logic [31:0] pixel_color;
  } item_t;

  // One result
  typedef struct packed {
    logic        status;
    logic [31:0] read_color;
  } result_t;

  // Screen geometry after saturation, as the sequencer sees it
  typedef struct packed {
    logic [7:0]          width;
    logic [7:0]          height;
    logic [2:0]          bytes;
    logic                word;
    logic [STRIDE_W-1:0] stride;
  } cfg_eff_t;

  // Multiply a pixel count by a depth of 1 to 4 bytes with shifts and one add
  function automatic logic [LEN_W-1:0] times_bytes(input logic [7:0] v,
                                                   input logic [2:0] b);
    logic [LEN_W-1:0] v10;
    logic [LEN_W-1:0] r;
    v10 = LEN_W'(v);
    case (b)
      3'd2:    r = v10 << 1;
      3'd3:    r = v10 + (v10 << 1);
      3'd4:    r = v10 << 2;
      default: r = v10;
    endcase
    return r;
  endfunction

endpackage

[rtl/fbrf_pixel_mem.sv]
// One framebuffer: byte-wide memory with one write port and one registered read port.
module fbrf_pixel_mem #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  // Write one byte and return a registered read byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/fbrf_ctrl.sv]
// Command sequencer: memory clearing pass, bounds check and rectangle walk.
module fbrf_ctrl import fbrf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  item_t                        item,
  input  cfg_eff_t                     cfg,
  output logic                         res_valid,
  input  logic                         res_ready,
  output result_t                      res,
  output logic [BUFFER_COUNT-1:0]      mem_we,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT*4)-1:0] mem_waddr,
  output logic [7:0]                   mem_wdata,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT*4)-1:0] mem_raddr,
  input  logic [7:0]                   mem_rdata [BUFFER_COUNT]
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT * 4;
  localparam int ADDR_W = $clog2(DEPTH);

  state_e state, state_next;

  item_t             item_q;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] row_base;
  logic [LEN_W-1:0]  j;
  logic [LEN_W-1:0]  row_last;
  logic [7:0]        row_idx;
  logic [7:0]        rows_last;
  logic [1:0]        lane;
  logic              status_q;
  logic [31:0]       rd_acc;
  logic              get_pend;
  logic [1:0]        get_lane;
  logic              cp_we;
  logic [ADDR_W-1:0] cp_addr;

  logic              is_point;
  logic              reject;
  logic              empty;
  logic [8:0]        x_end;
  logic [8:0]        y_end;
  logic [LEN_W-1:0]  xb;
  logic [OFF_W-1:0]  y_off;
  logic [ADDR_W-1:0] base_init;
  logic [LEN_W-1:0]  len_init;
  logic [7:0]        rows_init;
  logic [ADDR_W-1:0] walk_addr;
  logic              row_end;
  logic              walk_last;
  logic [1:0]        lane_eff;
  logic [1:0]        lane_last;
  logic [2:0]        bytes_m1;
  logic              clr_last;
  logic [7:0]        color_byte;

  // Bounds check and start address of the request
  assign is_point  = (item_q.command == CMD_SET_PIXEL) || (item_q.command == CMD_GET_PIXEL);
  assign x_end     = {1'b0, item_q.pos_x} + {1'b0, item_q.rect_width};
  assign y_end     = {1'b0, item_q.pos_y} + {1'b0, item_q.rect_height};
  assign reject    = is_point ? ((item_q.pos_x >= cfg.width) || (item_q.pos_y >= cfg.height))
                              : ((x_end > {1'b0, cfg.width}) || (y_end > {1'b0, cfg.height}));
  assign xb        = times_bytes(item_q.pos_x, cfg.bytes);
  assign y_off     = OFF_W'(item_q.pos_y) * OFF_W'(cfg.stride);
  assign base_init = ADDR_W'(y_off + OFF_W'(xb));
  assign len_init  = is_point ? (cfg.word ? LEN_W'(cfg.bytes) : LEN_W'(1))
                              : times_bytes(item_q.rect_width, cfg.bytes);
  assign rows_init = is_point ? 8'd1 : item_q.rect_height;
  assign empty     = (len_init == '0) || (rows_init == '0) ||
                     ((item_q.command == CMD_COPY_RECT) &&
                      (item_q.source_buffer == item_q.target_buffer));

  // Walk position inside the rectangle
  assign walk_addr = row_base + ADDR_W'(j);
  assign row_end   = (j == row_last);
  assign walk_last = row_end && (row_idx == rows_last);
  assign bytes_m1  = cfg.bytes - 3'd1;
  assign lane_last = bytes_m1[1:0];
  assign lane_eff  = cfg.word ? lane : 2'd0;
  assign clr_last  = (clr_addr == ADDR_W'(DEPTH - 1));

  // Pick the color byte for the current lane
  always_comb begin
    case (lane_eff)
      2'd1:    color_byte = item_q.pixel_color[15:8];
      2'd2:    color_byte = item_q.pixel_color[23:16];
      2'd3:    color_byte = item_q.pixel_color[31:24];
      default: color_byte = item_q.pixel_color[7:0];
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_last) state_next = ST_IDLE;
      ST_IDLE:   if (in_valid) state_next = ST_SETUP;
      ST_SETUP:  state_next = (reject || empty) ? ST_FINISH : ST_WALK;
      ST_WALK: begin
        if (walk_last) begin
          state_next = ((item_q.command == CMD_GET_PIXEL) ||
                        (item_q.command == CMD_COPY_RECT)) ? ST_DRAIN : ST_FINISH;
        end
      end
      ST_DRAIN:  state_next = ST_FINISH;
      ST_FINISH: if (res_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Handshakes and memory ports
  always_comb begin
    in_ready  = (state == ST_IDLE);
    res_valid = (state == ST_FINISH);
    mem_we    = '0;
    mem_waddr = walk_addr;
    mem_wdata = color_byte;
    mem_raddr = walk_addr;
    case (state)
      ST_CLEAR: begin
        mem_we    = '1;
        mem_waddr = clr_addr;
        mem_wdata = 8'h00;
      end
      ST_WALK: begin
        if ((item_q.command == CMD_SET_PIXEL) || (item_q.command == CMD_FILL_RECT)) begin
          mem_we[item_q.target_buffer] = 1'b1;
        end
      end
      default: ;
    endcase
    // Copy writes land in the cycle after their read
    if (cp_we) begin
      mem_we                       = '0;
      mem_we[item_q.target_buffer] = 1'b1;
      mem_waddr                    = cp_addr;
      mem_wdata                    = mem_rdata[item_q.source_buffer];
    end
  end

  assign res.status     = status_q;
  assign res.read_color = rd_acc;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      get_pend <= 1'b0;
      cp_we    <= 1'b0;
    end else begin
      state    <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      get_pend <= (state == ST_WALK) && (item_q.command == CMD_GET_PIXEL);
      cp_we    <= (state == ST_WALK) && (item_q.command == CMD_COPY_RECT);
    end
  end

  // Request capture, walk counters and read assembly
  always_ff @(posedge clk) begin
    cp_addr  <= walk_addr;
    get_lane <= lane_eff;
    if (in_valid && in_ready) begin
      item_q <= item;
    end
    if (state == ST_SETUP) begin
      status_q  <= reject;
      row_base  <= base_init;
      row_last  <= len_init - LEN_W'(1);
      rows_last <= rows_init - 8'd1;
      row_idx   <= '0;
      j         <= '0;
      lane      <= '0;
      rd_acc    <= '0;
    end
    if (state == ST_WALK) begin
      if (row_end) begin
        j        <= '0;
        lane     <= '0;
        row_base <= row_base + ADDR_W'(cfg.stride);
        row_idx  <= row_idx + 8'd1;
      end else begin
        j    <= j + LEN_W'(1);
        lane <= (lane == lane_last) ? 2'd0 : lane + 2'd1;
      end
    end
    if (get_pend) begin
      case (get_lane)
        2'd1:    rd_acc[15:8]  <= mem_rdata[item_q.target_buffer];
        2'd2:    rd_acc[23:16] <= mem_rdata[item_q.target_buffer];
        2'd3:    rd_acc[31:24] <= mem_rdata[item_q.target_buffer];
        default: rd_acc[7:0]   <= mem_rdata[item_q.target_buffer];
      endcase
    end
  end

endmodule

[rtl/framebuffer_region_fill_copy_unit.sv]
// Two-buffer framebuffer unit: set, get, fill and copy of pixel regions.
//
// Each buffer is a byte memory of MAX_WIDTH*MAX_HEIGHT*4 bytes, and all
// access goes through one byte per buffer per cycle, which sets the rate.
// After reset the unit clears all MAX_WIDTH*MAX_HEIGHT*4 bytes (65536 at
// the defaults) and takes no request until the pass ends; configuration
// writes are taken throughout. A request then passes through setup, a
// walk over its bytes (n for set and get pixel, with n = 4 or 2 in word
// modes, else 1; w*h*B for fill and copy), a drain step for get pixel and
// copy, and a finish state. A rejected or empty request, and a copy within
// one buffer, go from setup straight to finish. A finished result sits in
// an output register, so the next request is taken while it waits.
module framebuffer_region_fill_copy_unit import fbrf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Request stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // command[1:0], target_buffer[2], source_buffer[3], pos_x[11:4],
  // pos_y[19:12], rect_width[27:20], rect_height[35:28],
  // pixel_color[67:36], zero[71:68]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // status[0], read_color[32:1], zero[39:33]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // Configuration writes
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT * 4;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [7:0] MAX_W8 = 8'((MAX_WIDTH > 255) ? 255 : MAX_WIDTH);
  localparam logic [7:0] MAX_H8 = 8'((MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT);

  logic [7:0] disp_width;
  logic [7:0] disp_height;
  logic [2:0] pixel_bytes;

  logic [7:0] width_sat;
  logic [7:0] height_sat;
  logic [2:0] bytes_sat;
  cfg_eff_t   cfg_eff;

  item_t   item;
  result_t res;
  logic    res_valid;
  logic    res_ready;

  logic [BUFFER_COUNT-1:0] mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic [7:0]              mem_wdata;
  logic [ADDR_W-1:0]       mem_raddr;
  logic [7:0]              mem_rdata [BUFFER_COUNT];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      disp_width  <= 8'd128;
      disp_height <= 8'd128;
      pixel_bytes <= 3'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DISP_WIDTH:  disp_width  <= cfg_data;
        CFG_DISP_HEIGHT: disp_height <= cfg_data;
        CFG_PIXEL_BYTES: pixel_bytes <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Saturate geometry to the store size and the depth to 1..4
  assign width_sat  = (32'(disp_width) > MAX_WIDTH) ? MAX_W8 : disp_width;
  assign height_sat = (32'(disp_height) > MAX_HEIGHT) ? MAX_H8 : disp_height;
  assign bytes_sat  = (pixel_bytes == 3'd0) ? 3'd1 :
                      (pixel_bytes > 3'd4)  ? 3'd4 : pixel_bytes;

  // Hold the effective geometry and stride in registers
  always_ff @(posedge clk) begin
    cfg_eff.width  <= width_sat;
    cfg_eff.height <= height_sat;
    cfg_eff.bytes  <= bytes_sat;
    cfg_eff.word   <= (bytes_sat == 3'd4) || (bytes_sat == 3'd2);
    cfg_eff.stride <= STRIDE_W'(times_bytes(width_sat, bytes_sat));
  end

  // Unpack the request
  assign item.command       = cmd_e'(s_tdata[1:0]);
  assign item.target_buffer = s_tdata[2];
  assign item.source_buffer = s_tdata[3];
  assign item.pos_x         = s_tdata[11:4];
  assign item.pos_y         = s_tdata[19:12];
  assign item.rect_width    = s_tdata[27:20];
  assign item.rect_height   = s_tdata[35:28];
  assign item.pixel_color   = s_tdata[67:36];

  fbrf_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .item      (item),
    .cfg       (cfg_eff),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // One byte memory per framebuffer
  for (genvar b = 0; b < BUFFER_COUNT; b++) begin : g_buf
    fbrf_pixel_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
    ) u_mem (
      .clk   (clk),
      .we    (mem_we[b]),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata[b])
    );
  end

  // Output register: load a finished result when the slot is free
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {7'b0, res.read_color, res.status};
    end
  end

endmodule

[test/tb_framebuffer_region_fill_copy_unit.sv]
// Self-checking bench for the framebuffer unit: random and directed requests, shadow pixel store.
module tb_framebuffer_region_fill_copy_unit;
  import fbrf_pkg::*;

  localparam int FB_W          = MAX_WIDTH_DEF;
  localparam int FB_H          = MAX_HEIGHT_DEF;
  localparam int BUF_BYTES     = FB_W * FB_H * 4;
  localparam int STALL_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 16;
  localparam int SQUEEZE_AT    = 300;
  localparam int SQUEEZE_LEN   = 400;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = CFG_DISP_WIDTH;
  logic [7:0]            cfg_data = '0;

  // Shadow geometry, tracked from the write port
  logic [7:0] cfg_width  = 8'd128;
  logic [7:0] cfg_height = 8'd128;
  logic [2:0] cfg_depth  = 3'd4;

  // Shadow copy of both framebuffers, zero from the start
  bit [7:0] pix_mem [BUFFER_COUNT][BUF_BYTES];

  item_t   cmd_backlog [$];
  result_t results_due [$];
  item_t   offered_req = '0;
  item_t   next_req;
  result_t got_res, want_res;

  int  cmds_queued  = 0;
  int  cmds_taken   = 0;
  int  results_seen = 0;
  int  err_count    = 0;
  int  idle_cycles  = 0;
  int  tx_gap_left  = 0;
  int  rx_gap_left  = 0;
  int  rx_hold_left = 0;
  bit  squeeze_done = 1'b0;
  bit  req_taken    = 1'b0;
  bit  quiet        = 1'b0;

  framebuffer_region_fill_copy_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int eff_width();
    return (cfg_width > FB_W) ? FB_W : int'(cfg_width);
  endfunction

  function automatic int eff_height();
    return (cfg_height > FB_H) ? FB_H : int'(cfg_height);
  endfunction

  function automatic int eff_depth();
    if (cfg_depth == 3'd0) return 1;
    if (cfg_depth > 3'd4) return 4;
    return int'(cfg_depth);
  endfunction

  function automatic void note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("MISMATCH: %s", msg);
  endfunction

  // command[1:0], target_buffer[2], source_buffer[3], pos_x[11:4], pos_y[19:12],
  // rect_width[27:20], rect_height[35:28], pixel_color[67:36], zero[71:68]
  function automatic logic [IN_DATA_W-1:0] pack_req(input item_t r);
    return {4'b0, r.pixel_color, r.rect_height, r.rect_width, r.pos_y, r.pos_x,
            r.source_buffer, r.target_buffer, r.command};
  endfunction

  // Apply one request to the shadow store and return its result
  function automatic result_t run_blit(input item_t r);
    result_t res;
    int wd, ht, bpp, stride, base, n, px, py, rw, rh, i, j, k;
    bit word_mode;
    wd = eff_width();
    ht = eff_height();
    bpp = eff_depth();
    word_mode = (bpp == 4 || bpp == 2);
    stride = wd * bpp;
    px = int'(r.pos_x);
    py = int'(r.pos_y);
    rw = int'(r.rect_width);
    rh = int'(r.rect_height);
    res = '0;
    if (r.command == CMD_SET_PIXEL || r.command == CMD_GET_PIXEL) begin
      if (px >= wd || py >= ht) begin
        res.status = 1'b1;
      end else begin
        base = py * stride + px * bpp;
        n = word_mode ? bpp : 1;
        for (k = 0; k < n; k++) begin
          if (r.command == CMD_SET_PIXEL) begin
            pix_mem[r.target_buffer][base + k] = r.pixel_color[8 * k +: 8];
          end else begin
            res.read_color[8 * k +: 8] = pix_mem[r.target_buffer][base + k];
          end
        end
      end
    end else if (px + rw > wd || py + rh > ht) begin
      res.status = 1'b1;
    end else begin
      // walk row by row; a copy within one buffer rewrites the same bytes
      for (i = 0; i < rh; i++) begin
        base = (py + i) * stride + px * bpp;
        for (j = 0; j < rw * bpp; j++) begin
          if (r.command == CMD_FILL_RECT) begin
            pix_mem[r.target_buffer][base + j] =
              word_mode ? r.pixel_color[8 * (j % bpp) +: 8] : r.pixel_color[7:0];
          end else begin
            pix_mem[r.target_buffer][base + j] = pix_mem[r.source_buffer][base + j];
          end
        end
      end
    end
    return res;
  endfunction

  // Random request shaped by the current geometry
  function automatic item_t rand_blit();
    item_t r;
    int wd, ht, roll, reach_x, reach_y, cap;
    wd = eff_width();
    ht = eff_height();
    roll = $urandom_range(0, 99);
    r.command = cmd_e'($urandom_range(0, 3));
    r.target_buffer = 1'($urandom_range(0, 1));
    r.source_buffer = 1'($urandom_range(0, 1));
    r.pixel_color = $urandom;
    if (roll < 10 || wd == 0 || ht == 0) begin
      // full-range noise, mostly out of bounds
      r.pos_x = 8'($urandom);
      r.pos_y = 8'($urandom);
      r.rect_width = 8'($urandom);
      r.rect_height = 8'($urandom);
    end else if (roll < 22) begin
      // straddle the right and bottom edges: just inside or one past
      r.pos_x = 8'($urandom_range(wd > 4 ? wd - 4 : 0, wd));
      r.pos_y = 8'($urandom_range(ht > 4 ? ht - 4 : 0, ht));
      r.rect_width = 8'(wd - int'(r.pos_x) + int'($urandom_range(0, 1)));
      r.rect_height = 8'(ht - int'(r.pos_y) + int'($urandom_range(0, 1)));
    end else begin
      // keep most traffic near the origin so gets find earlier writes
      reach_x = (roll < 85 && wd > 16) ? 16 : wd;
      reach_y = (roll < 85 && ht > 16) ? 16 : ht;
      cap = (roll >= 98) ? 32 : 8;
      r.pos_x = 8'($urandom_range(0, reach_x - 1));
      r.pos_y = 8'($urandom_range(0, reach_y - 1));
      r.rect_width = 8'($urandom_range(0, (wd - int'(r.pos_x) < cap) ?
                                          wd - int'(r.pos_x) : cap));
      r.rect_height = 8'($urandom_range(0, (ht - int'(r.pos_y) < cap) ?
                                           ht - int'(r.pos_y) : cap));
    end
    return r;
  endfunction

  task automatic push_blit(input cmd_e c, input logic tgt, input logic src,
                           input int px, input int py, input int rw, input int rh,
                           input logic [31:0] color);
    item_t r;
    r.command = c;
    r.target_buffer = tgt;
    r.source_buffer = src;
    r.pos_x = 8'(px);
    r.pos_y = 8'(py);
    r.rect_width = 8'(rw);
    r.rect_height = 8'(rh);
    r.pixel_color = color;
    cmd_backlog.push_back(r);
    cmds_queued++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(input int wd, input int ht, input int bpp);
    write_reg(CFG_DISP_WIDTH, 8'(wd));
    write_reg(CFG_DISP_HEIGHT, 8'(ht));
    write_reg(CFG_PIXEL_BYTES, 8'(bpp));
    @(negedge clk);
  endtask

  // Wait until every request is taken and answered, then let the unit go quiet
  task automatic settle();
    do @(negedge clk); while (cmds_taken != cmds_queued || results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_random(input int count);
    repeat (count) begin
      cmd_backlog.push_back(rand_blit());
      cmds_queued++;
    end
    settle();
  endtask

  // Request driver: hold until taken, otherwise idle in bursts or offer the next
  always @(negedge clk) begin
    if (s_tvalid && !req_taken) begin
      s_tvalid <= 1'b1;
    end else if (tx_gap_left > 0) begin
      tx_gap_left--;
      s_tvalid <= 1'b0;
    end else if (rst || cmd_backlog.size() == 0) begin
      s_tvalid <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      tx_gap_left = $urandom_range(1, 15) - 1;
      s_tvalid <= 1'b0;
    end else begin
      next_req = cmd_backlog.pop_front();
      offered_req <= next_req;
      s_tdata <= pack_req(next_req);
      s_tvalid <= 1'b1;
    end
  end

  // Result receiver: random stall bursts and one long hold-off
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      m_tready <= 1'b0;
    end else if (!squeeze_done && results_seen >= SQUEEZE_AT) begin
      squeeze_done = 1'b1;
      rx_hold_left = SQUEEZE_LEN - 1;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      rx_gap_left = $urandom_range(1, 15) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: track register writes, predict taken requests, check results
  always @(posedge clk) begin
    if (rst) begin
      req_taken = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DISP_WIDTH:  cfg_width = cfg_data;
          CFG_DISP_HEIGHT: cfg_height = cfg_data;
          CFG_PIXEL_BYTES: cfg_depth = cfg_data[2:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got_res.status = m_tdata[0];
        got_res.read_color = m_tdata[32:1];
        results_seen++;
        if (results_due.size() == 0) begin
          note_error($sformatf("unrequested result: status %0d color %08h",
                               got_res.status, got_res.read_color));
        end else begin
          want_res = results_due.pop_front();
          if (got_res.status !== want_res.status)
            note_error($sformatf("result %0d status: expected %0d, got %0d",
                                 results_seen, want_res.status, got_res.status));
          if (got_res.read_color !== want_res.read_color)
            note_error($sformatf("result %0d read_color: expected %08h, got %08h",
                                 results_seen, want_res.read_color, got_res.read_color));
        end
      end
      req_taken = s_tvalid && s_tready;
      if (req_taken) begin
        results_due.push_back(run_blit(offered_req));
        cmds_taken++;
      end
    end
  end

  // Watchdog: end the run after too long without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_framebuffer_region_fill_copy_unit: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset geometry: pixel extremes, bounds, empty and full-screen rectangles
    push_blit(CMD_GET_PIXEL, 1'b0, 1'b0, 0, 0, 0, 0, 32'h0);
    push_blit(CMD_SET_PIXEL, 1'b0, 1'b1, 0, 0, 0, 0, 32'hFFFF_FFFF);
    push_blit(CMD_GET_PIXEL, 1'b0, 1'b0, 0, 0, 0, 0, 32'h0);
    push_blit(CMD_SET_PIXEL, 1'b1, 1'b0, 127, 127, 255, 255, 32'h8000_0001);
    push_blit(CMD_GET_PIXEL, 1'b1, 1'b0, 127, 127, 0, 0, 32'h0);
    push_blit(CMD_SET_PIXEL, 1'b0, 1'b0, 128, 0, 0, 0, 32'h1234_5678);
    push_blit(CMD_GET_PIXEL, 1'b0, 1'b0, 0, 128, 0, 0, 32'h0);
    push_blit(CMD_GET_PIXEL, 1'b1, 1'b1, 255, 255, 0, 0, 32'hFFFF_FFFF);
    push_blit(CMD_FILL_RECT, 1'b0, 1'b0, 3, 3, 0, 7, 32'hDEAD_BEEF);
    push_blit(CMD_FILL_RECT, 1'b0, 1'b0, 0, 0, 255, 1, 32'hDEAD_BEEF);
    push_blit(CMD_FILL_RECT, 1'b1, 1'b0, 128, 128, 0, 0, 32'hDEAD_BEEF);
    push_blit(CMD_FILL_RECT, 1'b0, 1'b0, 0, 0, 128, 128, 32'h5AA5_C33C);
    push_blit(CMD_GET_PIXEL, 1'b0, 1'b0, 64, 100, 0, 0, 32'h0);
    push_blit(CMD_COPY_RECT, 1'b1, 1'b0, 0, 0, 128, 128, 32'h0);
    push_blit(CMD_GET_PIXEL, 1'b1, 1'b0, 127, 0, 0, 0, 32'h0);
    push_blit(CMD_COPY_RECT, 1'b0, 1'b0, 10, 10, 20, 20, 32'h0);
    push_blit(CMD_FILL_RECT, 1'b1, 1'b0, 127, 0, 1, 128, 32'h0000_0000);
    push_blit(CMD_COPY_RECT, 1'b0, 1'b1, 120, 0, 9, 1, 32'h0);
    push_blit(CMD_COPY_RECT, 1'b0, 1'b1, 126, 126, 2, 2, 32'h0);
    push_blit(CMD_GET_PIXEL, 1'b0, 1'b0, 127, 127, 0, 0, 32'h0);
    push_blit(CMD_FILL_RECT, 1'b1, 1'b1, 255, 255, 255, 255, 32'hFFFF_FFFF);
    push_blit(CMD_GET_PIXEL, 1'b1, 1'b0, 127, 5, 0, 0, 32'h0);
    settle();

    // One-pixel screen, byte-wise depth
    set_geometry(1, 1, 1);
    push_blit(CMD_SET_PIXEL, 1'b0, 1'b0, 0, 0, 0, 0, 32'h1234_5678);
    push_blit(CMD_GET_PIXEL, 1'b0, 1'b0, 0, 0, 0, 0, 32'h0);
    push_blit(CMD_FILL_RECT, 1'b1, 1'b0, 0, 0, 1, 1, 32'hABCD_EF99);
    push_blit(CMD_GET_PIXEL, 1'b1, 1'b0, 0, 0, 0, 0, 32'h0);
    push_blit(CMD_SET_PIXEL, 1'b0, 1'b0, 1, 0, 0, 0, 32'h1);
    push_blit(CMD_FILL_RECT, 1'b0, 1'b0, 0, 0, 1, 2, 32'h1);
    run_random(100);

    // Zero-size screen and depth zero: only empty rectangles pass
    set_geometry(0, 0, 0);
    push_blit(CMD_GET_PIXEL, 1'b0, 1'b0, 0, 0, 0, 0, 32'h0);
    push_blit(CMD_FILL_RECT, 1'b0, 1'b0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    run_random(60);

    // Oversized registers saturate to the full store
    set_geometry(255, 255, 7);
    run_random(250);

    set_geometry(17, 9, 3);
    run_random(250);

    set_geometry(40, 30, 2);
    run_random(250);

    set_geometry(5, 3, 6);
    run_random(150);

    // Final stretch without idling on either side
    quiet = 1'b1;
    set_geometry(128, 128, 1);
    run_random(250);

    if (err_count == 0 && results_due.size() == 0) begin
      $display("tb_framebuffer_region_fill_copy_unit: done, clean");
    end else begin
      $display("tb_framebuffer_region_fill_copy_unit: done, errors");
    end
    $finish;
  end

endmodule
